// ----- hw/rtl/gdi_pkg.sv -----
package gdi_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int WDAY_W   = 3;
  localparam int MLEN_W   = 5;
  localparam int ORD_W    = 9;
  localparam int YLEN_W   = 9;
  localparam int WEEK_W   = 6;
  localparam int SUM_W    = 16;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_YEAR = 1'b0,
    CFG_MAX_YEAR = 1'b1
  } cfg_idx_t;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1600;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd6399;

  // proleptic offset: (year - 1) + 400 keeps the weekday sum non-negative
  localparam logic [YEAR_W:0] YEAR_OFS = 15'd399;

  // floor(x / 100) = (x * 5243) >> 19, exact for x below 2**15
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          SHIFT_100 = 19;

  // floor(x / 7) = (x * 293) >> 11, exact for x below 400
  localparam logic [8:0]  RECIP_7   = 9'd293;
  localparam int          SHIFT_7   = 11;

  // days before the start of month idx (idx 0 is January), idx 12 is the year length
  function automatic logic [ORD_W-1:0] cum_days(input logic lp, input logic [MONTH_W-1:0] idx);
    logic [ORD_W-1:0] v;
    logic [ORD_W-1:0] adj;
    adj = (lp && idx >= 4'd2) ? 9'd1 : 9'd0;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      4'd12:   v = 9'd365;
      default: v = 9'd0;
    endcase
    if (idx > 4'd12) begin
      adj = 9'd0;
    end
    return v + adj;
  endfunction

endpackage

// ----- hw/rtl/gdi_if.sv -----
interface gdi_in_if;
  import gdi_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;

  modport source (output valid, output year, output month, output day, input ready);
  modport sink   (input valid, input year, input month, input day, output ready);
endinterface

interface gdi_out_if;
  import gdi_pkg::*;

  logic              valid;
  logic              ready;
  logic              valid_res;
  logic              leap;
  logic [WDAY_W-1:0] weekday;
  logic [MLEN_W-1:0] month_length;
  logic [ORD_W-1:0]  ordinal;
  logic [YLEN_W-1:0] year_length;
  logic [WEEK_W-1:0] week_number;

  modport source (
    output valid, output valid_res, output leap, output weekday, output month_length,
    output ordinal, output year_length, output week_number, input ready
  );
  modport sink (
    input valid, input valid_res, input leap, input weekday, input month_length,
    input ordinal, input year_length, input week_number, output ready
  );
endinterface

// ----- hw/rtl/gdi_mod7.sv -----
module gdi_mod7 (
  input  logic [gdi_pkg::SUM_W-1:0]  val,
  output logic [gdi_pkg::WDAY_W-1:0] rem
);
  import gdi_pkg::*;

  // 8 is 1 mod 7, so octal digits can be summed
  logic [5:0] fold1;
  logic [3:0] fold2;

  always_comb begin
    fold1 = 6'(val[2:0]) + 6'(val[5:3]) + 6'(val[8:6]) + 6'(val[11:9])
          + 6'(val[14:12]) + 6'(val[15]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    rem   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  end

endmodule

// ----- hw/rtl/gregorian_date_info.sv -----
// gregorian date check with leap flag, weekday, month length, day of year and week of year
// throughput: one item per cycle while the output is not stalled; set by the six-stage
// pipeline, at most one reciprocal multiply a stage
// each stage holds its item only while the stage after it is full and stalled
// reset (rst_n low, synchronous): pipeline emptied, min_year 1600, max_year 6399
module gregorian_date_info (
  input  logic                            clk,
  input  logic                            rst_n,
  gdi_in_if.sink                          in_chan,
  gdi_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [gdi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gdi_pkg::YEAR_W-1:0]      cfg_wdata
);
  import gdi_pkg::*;

  // configuration registers
  logic [YEAR_W-1:0] min_year_r;
  logic [YEAR_W-1:0] max_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
      max_year_r <= MAX_YEAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_YEAR: min_year_r <= cfg_wdata;
        CFG_MAX_YEAR: max_year_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage load enables; a stage loads when it is empty
  // or when the stage after it moves on, so bubbles are squeezed out
  logic [6:1] v_r;
  logic [6:1] en;

  always_comb begin
    en[6] = !v_r[6] || out_chan.ready;
    en[5] = !v_r[5] || en[6];
    en[4] = !v_r[4] || en[5];
    en[3] = !v_r[3] || en[4];
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
  end

  assign in_chan.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_chan.valid;
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
      if (en[5]) v_r[5] <= v_r[4];
      if (en[6]) v_r[6] <= v_r[5];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: year limit check, offset year, reciprocal multiply for year / 100
  logic [YEAR_W:0]    p_nxt;
  logic [26:0]        prod_y_nxt;
  logic               year_ok_nxt;

  logic [YEAR_W-1:0]  s1_y_r;
  logic [YEAR_W:0]    s1_p_r;
  logic [MONTH_W-1:0] s1_m_r;
  logic [DAY_W-1:0]   s1_d_r;
  logic [26:0]        s1_prod_y_r;
  logic               s1_year_ok_r;

  always_comb begin
    p_nxt       = {1'b0, in_chan.year} + YEAR_OFS;
    prod_y_nxt  = 27'(in_chan.year) * 27'(RECIP_100);
    year_ok_nxt = (in_chan.year >= min_year_r) && (in_chan.year <= max_year_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_y_r       <= in_chan.year;
      s1_p_r       <= p_nxt;
      s1_m_r       <= in_chan.month;
      s1_d_r       <= in_chan.day;
      s1_prod_y_r  <= prod_y_nxt;
      s1_year_ok_r <= year_ok_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: leap rule from year / 100 and year % 100, month check, multiply for p / 100
  logic [7:0]         qy;
  logic [YEAR_W-1:0]  r100;
  logic               leap_nxt;
  logic [27:0]        prod_p_nxt;
  logic               month_ok_nxt;

  logic [YEAR_W:0]    s2_p_r;
  logic [MONTH_W-1:0] s2_m_r;
  logic [DAY_W-1:0]   s2_d_r;
  logic [27:0]        s2_prod_p_r;
  logic               s2_leap_r;
  logic               s2_ym_ok_r;

  always_comb begin
    qy           = s1_prod_y_r[SHIFT_100 +: 8];
    r100         = s1_y_r - 14'({6'd0, qy} * 14'd100);
    // divisible by 4 but not 100, or divisible by 400
    leap_nxt     = ((s1_y_r[1:0] == 2'd0) && (r100 != '0))
                || ((r100 == '0) && (qy[1:0] == 2'd0));
    prod_p_nxt   = 28'(s1_p_r) * 28'(RECIP_100);
    month_ok_nxt = (s1_m_r >= 4'd1) && (s1_m_r <= 4'd12);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_p_r      <= s1_p_r;
      s2_m_r      <= s1_m_r;
      s2_d_r      <= s1_d_r;
      s2_prod_p_r <= prod_p_nxt;
      s2_leap_r   <= leap_nxt;
      s2_ym_ok_r  <= s1_year_ok_r && month_ok_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: weekday year sum p + p/4 - p/100 + p/400 + 1, month offsets
  logic [7:0]         q100;
  logic [SUM_W-1:0]   sum_nxt;
  logic [ORD_W-1:0]   cum_lo;
  logic [ORD_W-1:0]   cum_hi;
  logic [ORD_W-1:0]   mlen_full;

  logic [SUM_W-1:0]   s3_sum_r;
  logic [ORD_W-1:0]   s3_lo_r;
  logic [MLEN_W-1:0]  s3_mlen_r;
  logic [DAY_W-1:0]   s3_d_r;
  logic               s3_leap_r;
  logic               s3_ym_ok_r;

  always_comb begin
    q100      = s2_prod_p_r[SHIFT_100 +: 8];
    sum_nxt   = 16'(s2_p_r) + 16'(s2_p_r >> 2) - 16'(q100) + 16'(q100 >> 2) + 16'd1;
    // an index past the end (above 12) reads zero; month 0 wraps to index 15
    cum_lo    = cum_days(s2_leap_r, s2_m_r - 4'd1);
    cum_hi    = cum_days(s2_leap_r, s2_m_r);
    mlen_full = cum_hi - cum_lo;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_sum_r   <= sum_nxt;
      s3_lo_r    <= cum_lo;
      s3_mlen_r  <= mlen_full[MLEN_W-1:0];
      s3_d_r     <= s2_d_r;
      s3_leap_r  <= s2_leap_r;
      s3_ym_ok_r <= s2_ym_ok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: day check, ordinal and weekday sum of the date
  logic [ORD_W-1:0]   ord_nxt;
  logic               day_ok_nxt;

  logic [SUM_W-1:0]   s4_sum0_r;
  logic [SUM_W-1:0]   s4_sum1_r;
  logic [ORD_W-1:0]   s4_ord_r;
  logic [MLEN_W-1:0]  s4_mlen_r;
  logic               s4_leap_r;
  logic               s4_ok_r;

  always_comb begin
    ord_nxt    = s3_lo_r + 9'(s3_d_r) - 9'd1;
    day_ok_nxt = (s3_d_r != '0) && (s3_d_r <= s3_mlen_r);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_sum0_r <= s3_sum_r;
      s4_sum1_r <= s3_sum_r + 16'(ord_nxt);
      s4_ord_r  <= ord_nxt;
      s4_mlen_r <= s3_mlen_r;
      s4_leap_r <= s3_leap_r;
      s4_ok_r   <= s3_ym_ok_r && day_ok_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: weekday of january 1 and of the date, both mod 7
  logic [WDAY_W-1:0]  base_wd;
  logic [WDAY_W-1:0]  date_wd;

  logic [ORD_W-1:0]   s5_x_r;
  logic [WDAY_W-1:0]  s5_wd_r;
  logic [ORD_W-1:0]   s5_ord_r;
  logic [MLEN_W-1:0]  s5_mlen_r;
  logic               s5_leap_r;
  logic               s5_ok_r;

  gdi_mod7 u_mod7_base (
    .val (s4_sum0_r),
    .rem (base_wd)
  );

  gdi_mod7 u_mod7_date (
    .val (s4_sum1_r),
    .rem (date_wd)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_x_r    <= s4_ord_r + 9'(base_wd);
      s5_wd_r   <= date_wd;
      s5_ord_r  <= s4_ord_r;
      s5_mlen_r <= s4_mlen_r;
      s5_leap_r <= s4_leap_r;
      s5_ok_r   <= s4_ok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: week number and output register; an invalid date gives all zeros
  logic [17:0]        wk_prod;
  logic [WEEK_W-1:0]  week_nxt;

  logic               o_ok_r;
  logic               o_leap_r;
  logic [WDAY_W-1:0]  o_wd_r;
  logic [MLEN_W-1:0]  o_mlen_r;
  logic [ORD_W-1:0]   o_ord_r;
  logic [YLEN_W-1:0]  o_ylen_r;
  logic [WEEK_W-1:0]  o_week_r;

  always_comb begin
    wk_prod  = 18'(s5_x_r) * 18'(RECIP_7);
    week_nxt = 6'(wk_prod[17:SHIFT_7]) + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      o_ok_r   <= s5_ok_r;
      o_leap_r <= s5_ok_r && s5_leap_r;
      o_wd_r   <= s5_ok_r ? s5_wd_r   : '0;
      o_mlen_r <= s5_ok_r ? s5_mlen_r : '0;
      o_ord_r  <= s5_ok_r ? s5_ord_r  : '0;
      o_ylen_r <= s5_ok_r ? (s5_leap_r ? 9'd366 : 9'd365) : '0;
      o_week_r <= s5_ok_r ? week_nxt  : '0;
    end
  end

  assign out_chan.valid        = v_r[6];
  assign out_chan.valid_res    = o_ok_r;
  assign out_chan.leap         = o_leap_r;
  assign out_chan.weekday      = o_wd_r;
  assign out_chan.month_length = o_mlen_r;
  assign out_chan.ordinal      = o_ord_r;
  assign out_chan.year_length  = o_ylen_r;
  assign out_chan.week_number  = o_week_r;

endmodule

// ----- hw/rtl/gdi_checker.sv -----
module gdi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          valid_res,
  input logic                          leap,
  input logic [gdi_pkg::WDAY_W-1:0]    weekday,
  input logic [gdi_pkg::MLEN_W-1:0]    month_length,
  input logic [gdi_pkg::ORD_W-1:0]     ordinal,
  input logic [gdi_pkg::YLEN_W-1:0]    year_length,
  input logic [gdi_pkg::WEEK_W-1:0]    week_number
);
  import gdi_pkg::*;

  // an invalid date shows zeros in every field
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> !leap && weekday == '0 && month_length == '0
      && ordinal == '0 && year_length == '0 && week_number == '0)
    else $error("invalid date with nonzero fields");

  // year length follows the leap flag, month length and weekday in range
  a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && valid_res |-> year_length == (leap ? 9'd366 : 9'd365)
      && weekday <= 3'd6 && month_length >= 5'd28 && month_length <= 5'd31)
    else $error("valid result with fields out of range");

  // ordinal inside the year, week number consistent with the ordinal
  a_ordinal_week: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && valid_res |-> ordinal < year_length && week_number >= 6'd1
      && (12'(week_number) * 12'd7) > 12'(ordinal)
      && (12'(week_number) * 12'd7) <= 12'(ordinal) + 12'd13)
    else $error("ordinal or week number inconsistent");

  // a stalled result item holds its valid, valid_res, ordinal, weekday and week number
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(ordinal)
      && $stable(weekday) && $stable(week_number))
    else $error("stalled result item changed");

endmodule

bind gregorian_date_info gdi_checker u_gdi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .valid_res    (out_chan.valid_res),
  .leap         (out_chan.leap),
  .weekday      (out_chan.weekday),
  .month_length (out_chan.month_length),
  .ordinal      (out_chan.ordinal),
  .year_length  (out_chan.year_length),
  .week_number  (out_chan.week_number)
);
